/* hdl/satl_pkg.sv */
// Shared constants and types for the set-associative tag lookup.
// Holds address split, row layout of the tag/age memory and lookup result.
// No dependencies.
`default_nettype none

package satl_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int SET_BITS   = 7;
    localparam int WAY_BITS   = 2;
    localparam int LINE_BITS  = 5;
    localparam int AGE_WIDTH  = 16;

    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int NUM_WAYS  = 1 << WAY_BITS;
    localparam int TAG_BITS  = ADDR_WIDTH - SET_BITS - LINE_BITS;

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
    localparam logic [AGE_WIDTH-1:0] AGE_NEW = AGE_WIDTH'(1);

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [AGE_WIDTH-1:0] age;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    localparam int ROW_WIDTH = $bits(t_row);

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic                replaced;
        t_row                row;
    } t_lookup;

endpackage

`default_nettype wire

/* hdl/satl_way_sel.sv */
// Way selection for one set: tag compare, empty/victim choice and age update.
// Purely combinational; depends on satl_pkg.
`default_nettype none

module satl_way_sel (
    input  var satl_pkg::t_row                  i_row,
    input  var logic [satl_pkg::TAG_BITS-1:0]   i_tag,
    input  var logic                            i_random_replace,
    input  var logic [satl_pkg::WAY_BITS-1:0]   i_random_way,
    output satl_pkg::t_lookup                   o_lookup
);
    import satl_pkg::*;

    logic                 hit;
    logic                 empty_found;
    logic [WAY_BITS-1:0]  hit_way;
    logic [WAY_BITS-1:0]  empty_way;
    logic [WAY_BITS-1:0]  oldest_way;
    logic [AGE_WIDTH-1:0] oldest_age;
    logic [WAY_BITS-1:0]  sel_way;
    t_row                 new_row;

    // first matching way, first empty way, oldest way (lowest index on ties)
    always_comb begin
        hit         = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        oldest_way  = '0;
        oldest_age  = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit && i_row[w].age != '0 && i_row[w].tag == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!empty_found && i_row[w].age == '0) begin
                empty_found = 1'b1;
                empty_way   = WAY_BITS'(w);
            end
            if (i_row[w].age > oldest_age) begin
                oldest_age = i_row[w].age;
                oldest_way = WAY_BITS'(w);
            end
        end
    end

    always_comb begin
        if (hit) begin
            sel_way = hit_way;
        end else if (empty_found) begin
            sel_way = empty_way;
        end else if (i_random_replace) begin
            sel_way = i_random_way;
        end else begin
            sel_way = oldest_way;
        end
    end

    // selected way restarts at age one, other valid ways age and saturate
    always_comb begin
        new_row = i_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_BITS'(w) == sel_way) begin
                new_row[w].tag = i_tag;
                new_row[w].age = AGE_NEW;
            end else if (i_row[w].age != '0 && i_row[w].age != AGE_MAX) begin
                new_row[w].age = i_row[w].age + AGE_NEW;
            end
        end
    end

    assign o_lookup.hit      = hit;
    assign o_lookup.way      = sel_way;
    assign o_lookup.replaced = !hit && !empty_found;
    assign o_lookup.row      = new_row;

endmodule

`default_nettype wire

/* hdl/set_assoc_cache_tag_lookup.sv */
// Top level of the set-associative tag lookup: stream ports, tag/age memory,
// read-modify-write sequencer and output register. Uses satl_pkg, satl_way_sel.
//
//  channel    | direction | tdata (low bit up)                          | tuser
//  s_axis     | in        | address[31:0], random_way[33:32], 0 pad     | action
//  m_axis     | out       | hit[0], way_index[2:1], replaced_valid[3]   | -
//  cfg        | in        | random_replace on i_cfg_wdata with i_cfg_we | -
//
// Each item first reads the set's row from the single-port tag/age memory,
// then compares, updates and writes the row back.
// One item is in flight at a time; the next is taken while a result waits
// in the output register, but write-back waits until that register frees.
// Reset clears the per-set valid flags at once, so no clearing pass is needed;
// a clear action clears them all the same way.
`default_nettype none

module set_assoc_cache_tag_lookup (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  var logic [39:0] i_s_axis_tdata,   // address[31:0], random_way[33:32]
    input  var logic        i_s_axis_tuser,   // action
    output logic            o_m_axis_tvalid,
    input  var logic        i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // hit[0], way_index[2:1], replaced_valid[3]
    input  var logic        i_cfg_we,
    input  var logic        i_cfg_wdata       // random_replace
);
    import satl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                  r_state;
    logic                  n_state;
    logic                  r_random_replace;
    logic                  r_action;
    logic [TAG_BITS-1:0]   r_tag;
    logic [SET_BITS-1:0]   r_set;
    logic [WAY_BITS-1:0]   r_rand;
    logic [NUM_SETS-1:0]   r_row_valid;
    logic                  r_rd_valid;
    logic [ROW_WIDTH-1:0]  r_rd_data;
    logic [ROW_WIDTH-1:0]  r_mem [NUM_SETS];
    logic                  r_out_valid;
    logic [7:0]            r_out_data;

    logic                  in_xfer;
    logic                  out_free;
    logic                  finish;
    logic                  mem_we;
    logic [SET_BITS-1:0]   in_set;
    t_row                  rd_row;
    t_lookup               lookup;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign finish   = (r_state == ST_LOOK) && out_free;
    assign mem_we   = finish && (r_action == ACT_LOOKUP);
    assign in_set   = i_s_axis_tdata[LINE_BITS +: SET_BITS];
    assign rd_row   = r_rd_valid ? t_row'(r_rd_data) : '0;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    satl_way_sel u_way_sel (
        .i_row            (rd_row),
        .i_tag            (r_tag),
        .i_random_replace (r_random_replace),
        .i_random_way     (r_rand),
        .o_lookup         (lookup)
    );

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = in_xfer ? ST_LOOK : ST_IDLE;
            ST_LOOK: n_state = out_free ? ST_IDLE : ST_LOOK;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_random_replace <= 1'b1;
            r_row_valid      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_random_replace <= i_cfg_wdata;
            end
            if (finish) begin
                if (r_action == ACT_CLEAR) begin
                    r_row_valid <= '0;
                end else begin
                    r_row_valid[r_set] <= 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the request and the set's valid flag with the memory read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action   <= i_s_axis_tuser;
            r_tag      <= i_s_axis_tdata[ADDR_WIDTH-1 -: TAG_BITS];
            r_set      <= in_set;
            r_rand     <= i_s_axis_tdata[ADDR_WIDTH +: WAY_BITS];
            r_rd_valid <= r_row_valid[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_set] <= ROW_WIDTH'(lookup.row);
        end
        if (in_xfer) begin
            r_rd_data <= r_mem[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_action == ACT_CLEAR) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {4'b0000, lookup.replaced, 2'(lookup.way), lookup.hit};
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/satl_chk.sv */
// Port-level checker for the tag lookup, attached to the top level by bind.
// Depends only on the top level's ports.
`default_nettype none

module satl_chk (
    input var logic        i_clk,
    input var logic        i_rst_n,
    input var logic        i_s_axis_tvalid,
    input var logic        o_s_axis_tready,
    input var logic [39:0] i_s_axis_tdata,
    input var logic        i_s_axis_tuser,
    input var logic        o_m_axis_tvalid,
    input var logic        i_m_axis_tready,
    input var logic [7:0]  o_m_axis_tdata,
    input var logic        i_cfg_we,
    input var logic        i_cfg_wdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while previous item in flight");

    a_hit_no_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> !o_m_axis_tdata[3])
        else $error("hit reported with replacement");

    // a clear taken with an empty output stage passes through the lookup state, then answers with zeros
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && !o_m_axis_tvalid
        |=> ##1 o_m_axis_tvalid && o_m_axis_tdata == 8'h00)
        else $error("clear result missing or nonzero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not idle after reset");

endmodule

bind set_assoc_cache_tag_lookup satl_chk u_satl_chk (.*);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for set_assoc_cache_tag_lookup: drives lookups and clears,
// predicts hit/way/eviction from a shadow tag and age array, and checks every result.
// Depends on satl_pkg and the RTL under hdl/.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import satl_pkg::*;

    localparam int SOAK_HITS   = 40;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 320;
    localparam int HOLD_CYCLES = 400;
    localparam int SLOTS       = NUM_SETS * NUM_WAYS;

    typedef struct {
        logic                  action;
        logic [ADDR_WIDTH-1:0] addr;
        logic [1:0]            rway;
    } t_access;

    typedef struct {
        logic       hit;
        logic [1:0] way;
        logic       replaced;
    } t_outcome;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata  = '0;   // address[31:0], random_way[33:32]
    logic        i_s_axis_tuser  = 1'b0; // action
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_wdata     = 1'b0; // random_replace
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;         // hit[0], way_index[2:1], replaced_valid[3]

    // shadow copy of the tag/age memory and the replacement mode
    logic [TAG_BITS-1:0]  shadow_tag [SLOTS] = '{default: '0};
    logic [AGE_WIDTH-1:0] shadow_age [SLOTS] = '{default: '0};
    logic                 random_mode = 1'b1;

    t_access  access_q[$];
    t_outcome outcome_q[$];
    t_access  offer;
    bit       offer_busy = 1'b0;
    bit       idle_on    = 1'b0;
    bit       hold_arm   = 1'b0;
    bit       hold_done  = 1'b0;
    int       send_gap   = 0;
    int       recv_gap   = 0;
    int       hold_left  = 0;
    int       n_hits     = 0;
    int       n_fills    = 0;
    int       n_evicts   = 0;
    int       n_clears   = 0;
    int       n_results  = 0;
    int       n_fail     = 0;

    set_assoc_cache_tag_lookup u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Make way keep the youngest; age the other valid ways, saturating.
    function automatic void refresh_ages(int base, int keep);
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == keep) begin
                shadow_age[base + w] = AGE_NEW;
            end else if (shadow_age[base + w] != '0 && shadow_age[base + w] != AGE_MAX) begin
                shadow_age[base + w] = shadow_age[base + w] + 1'b1;
            end
        end
    endfunction

    function automatic t_outcome predict_access(t_access a);
        t_outcome             res;
        logic [TAG_BITS-1:0]  tg;
        logic [AGE_WIDTH-1:0] oldest;
        int                   base;
        int                   victim;
        res = '{hit: 1'b0, way: 2'd0, replaced: 1'b0};
        if (a.action == ACT_CLEAR) begin
            foreach (shadow_tag[i]) begin
                shadow_tag[i] = '0;
                shadow_age[i] = '0;
            end
            n_clears++;
            return res;
        end
        tg   = a.addr[ADDR_WIDTH-1 -: TAG_BITS];
        base = int'(a.addr[LINE_BITS +: SET_BITS]) * NUM_WAYS;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (shadow_age[base + w] != '0 && shadow_tag[base + w] == tg) begin
                refresh_ages(base, w);
                res.hit = 1'b1;
                res.way = 2'(w);
                n_hits++;
                return res;
            end
        end
        victim = -1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (victim < 0 && shadow_age[base + w] == '0) victim = w;
        end
        if (victim < 0) begin
            res.replaced = 1'b1;
            n_evicts++;
            if (random_mode) begin
                victim = int'(a.rway[WAY_BITS-1:0]);
            end else begin
                // oldest way wins, lowest index on a tie
                oldest = '0;
                victim = 0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (shadow_age[base + w] > oldest) begin
                        oldest = shadow_age[base + w];
                        victim = w;
                    end
                end
            end
        end else begin
            n_fills++;
        end
        shadow_tag[base + victim] = tg;
        refresh_ages(base, victim);
        res.way = 2'(victim);
        return res;
    endfunction

    // Driver: predict on each accepted transfer, then offer the next queued access.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                outcome_q.push_back(predict_access(offer));
                offer_busy = 1'b0;
            end
            if (!offer_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (idle_on && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 4);
                end else if (access_q.size() != 0) begin
                    offer = access_q.pop_front();
                    offer_busy = 1'b1;
                    i_s_axis_tdata <= {6'b0, offer.rway, offer.addr};
                    i_s_axis_tuser <= offer.action;
                end
            end
            i_s_axis_tvalid <= offer_busy;
        end
    end

    // Monitor: check each result transfer against the oldest prediction, drive tready.
    always @(posedge i_clk) begin
        t_outcome want;
        logic     rdy;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    $error("result with no access pending: tdata %h", o_m_axis_tdata);
                    n_fail++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, o_m_axis_tdata[0]);
                        n_fail++;
                    end
                    if (o_m_axis_tdata[2:1] !== want.way) begin
                        $error("way_index: expected %0d, actual %0d",
                               want.way, o_m_axis_tdata[2:1]);
                        n_fail++;
                    end
                    if (o_m_axis_tdata[3] !== want.replaced) begin
                        $error("replaced_valid: expected %0d, actual %0d",
                               want.replaced, o_m_axis_tdata[3]);
                        n_fail++;
                    end
                end
            end
            rdy = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_arm && !hold_done) begin
                // long hold-off: let the block back up onto its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rdy = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                recv_gap = $urandom_range(0, 4);
                rdy = 1'b0;
            end
            i_m_axis_tready <= rdy;
        end
    end

    function automatic logic [ADDR_WIDTH-1:0] line_addr(logic [TAG_BITS-1:0] tg,
                                                        logic [SET_BITS-1:0] set_idx,
                                                        logic [LINE_BITS-1:0] offs);
        return {tg, set_idx, offs};
    endfunction

    task automatic queue_access(logic action, logic [ADDR_WIDTH-1:0] addr, logic [1:0] rway);
        access_q.push_back('{action: action, addr: addr, rway: rway});
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (access_q.size() != 0 || offer_busy || outcome_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(logic rnd);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rnd;
        random_mode = rnd;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly a few hot sets with small tag pools, so hits and evictions are common.
    task automatic queue_random(int count);
        logic [SET_BITS-1:0] hot_set [4];
        logic [TAG_BITS-1:0] hot_tag [4][6];
        int                  roll;
        int                  s;
        foreach (hot_set[i]) hot_set[i] = SET_BITS'($urandom);
        foreach (hot_tag[i, j]) hot_tag[i][j] = TAG_BITS'($urandom);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            s    = $urandom_range(0, 3);
            if (roll == 0) begin
                queue_access(ACT_CLEAR, $urandom, 2'($urandom));
            end else if (roll < 11) begin
                queue_access(ACT_LOOKUP, $urandom, 2'($urandom));
            end else begin
                queue_access(ACT_LOOKUP,
                             line_addr(hot_tag[s][$urandom_range(0, 5)], hot_set[s],
                                       LINE_BITS'($urandom)),
                             2'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random replacement
        set_mode(1'b1);
        queue_access(ACT_LOOKUP, 32'h0000_0000, 2'd3);   // zero tag in an empty way must miss
        queue_access(ACT_LOOKUP, 32'hFFFF_FFFF, 2'd0);
        queue_access(ACT_LOOKUP, 32'h0000_001F, 2'd1);   // same line, other offset: hit
        for (int t = 1; t < 4; t++) begin
            queue_access(ACT_LOOKUP, line_addr(TAG_BITS'(t), 7'd0, 5'h00), 2'd0);
        end
        queue_access(ACT_LOOKUP, line_addr(20'h4, 7'd0, 5'h10), 2'd2);
        queue_access(ACT_LOOKUP, line_addr(20'h5, 7'd0, 5'h01), 2'd0);
        queue_access(ACT_LOOKUP, line_addr(20'h6, 7'd0, 5'h02), 2'd3);
        queue_access(ACT_LOOKUP, line_addr(20'h7, 7'd0, 5'h03), 2'd1);
        queue_access(ACT_LOOKUP, line_addr(20'h4, 7'd0, 5'h1F), 2'd0);
        queue_access(ACT_CLEAR, 32'hFFFF_FFFF, 2'd3);
        queue_access(ACT_LOOKUP, 32'hFFFF_FFFF, 2'd2);   // miss after the clear

        // oldest-age replacement
        set_mode(1'b0);
        for (int t = 0; t < 4; t++) begin
            queue_access(ACT_LOOKUP, line_addr(20'hA0000 + TAG_BITS'(t), 7'd5, LINE_BITS'(t * 8)),
                         2'd3);
        end
        queue_access(ACT_LOOKUP, line_addr(20'hA0001, 7'd5, 5'h00), 2'd0);
        queue_access(ACT_LOOKUP, line_addr(20'hA0004, 7'd5, 5'h00), 2'd1);
        queue_access(ACT_LOOKUP, line_addr(20'hA0005, 7'd5, 5'h00), 2'd2);
        queue_access(ACT_CLEAR, 32'h0000_0000, 2'd0);

        // keep hitting way 0 so the other ways grow older, then a miss must evict
        // the oldest of them
        for (int w = 0; w < NUM_WAYS; w++) begin
            queue_access(ACT_LOOKUP, line_addr(20'hC000 + TAG_BITS'(w), 7'd9, 5'h00), 2'd0);
        end
        repeat (SOAK_HITS) begin
            queue_access(ACT_LOOKUP, line_addr(20'hC000, 7'd9, LINE_BITS'($urandom)),
                         2'($urandom));
        end
        queue_access(ACT_LOOKUP, line_addr(20'h12345, 7'd9, 5'h00), 2'd3);
        queue_access(ACT_LOOKUP, line_addr(20'hC002, 7'd9, 5'h00), 2'd0);
        queue_access(ACT_LOOKUP, line_addr(20'hC003, 7'd9, 5'h00), 2'd0);
        queue_access(ACT_LOOKUP, line_addr(20'hC000, 7'd9, 5'h00), 2'd0);

        for (int p = 0; p < PHASES; p++) begin
            set_mode((p % 2) == 0);
            idle_on = (p < PHASES - 1);
            if (p == 0) hold_arm = 1'b1;
            queue_random(PHASE_ITEMS);
        end
        drain();

        $display("covered %0d lookups (%0d hits, %0d fills, %0d evictions) and %0d clears",
                 n_hits + n_fills + n_evicts, n_hits, n_fills, n_evicts, n_clears);
        $display("both replacement modes, age ordering and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
